@@ sv/smce_pkg.sv @@
// Shared types, widths, codes and lookup tables for the softmax cross-entropy block.
package smce_pkg;

  // Limits and field widths
  localparam int DEF_MAX_VOCAB = 64;
  localparam int MAX_ROWS      = 1024;
  localparam int LOGIT_W       = 16;
  localparam int TGT_W         = 8;
  localparam int VCFG_W        = 7;
  localparam int RCFG_W        = 11;
  localparam int CFG_DW        = 11;
  localparam int CFG_IW        = 1;
  localparam int GRAD_W        = 18;
  localparam int GIDX_W        = 6;
  localparam int LOSS_W        = 24;
  localparam int LSUM_W        = 32;
  localparam int PROB_W        = 17;
  localparam int SUM_W         = 23;
  localparam int NUM_W         = 34;
  localparam int NEGLN_W       = 21;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_VOCAB = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_ROWS  = 1'b1;

  // Fixed-point constants
  localparam logic [PROB_W-1:0]  ONE_Q16      = 17'd65536;
  localparam logic [15:0]        LN2_Q16      = 16'd45426;
  localparam logic [NEGLN_W-1:0] EPS_LOSS_Q16 = 21'd1509022;
  localparam logic [LOGIT_W-1:0] LOGIT_MIN    = 16'h8000;

  typedef enum logic [4:0] {
    S_IDLE, S_EXP_RD, S_EXP_M1, S_EXP_M2, S_EXP_WR,
    S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_DIV_WR,
    S_LN1, S_LN2, S_LN3,
    S_MEAN_GO, S_MEAN_WAIT,
    S_EM_RD, S_EM_GO, S_EM_WAIT, S_EM_OUT
  } state_t;

  typedef enum logic [1:0] {DIV_PROB, DIV_MEAN, DIV_GRAD} div_op_t;

  typedef struct packed {
    logic    in_take;
    logic    row_clr;
    logic    v_clr;
    logic    v_inc;
    logic    sum_clr;
    logic    e_wr;
    logic    p_wr;
    logic    div_start;
    div_op_t div_op;
    logic    ln_upd;
    logic    mean_take;
    logic    out_load;
  } smce_cmd_t;

  typedef struct packed {
    logic v_last;
    logic sum_zero;
    logic div_done;
    logic seq_end;
    logic out_free;
  } smce_stat_t;

  // exp(-i), Q16
  function automatic logic [16:0] exp_int(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-i/16), Q16
  function automatic logic [16:0] exp_hi(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd61565;
      4'd2:  r = 17'd57835;
      4'd3:  r = 17'd54331;
      4'd4:  r = 17'd51039;
      4'd5:  r = 17'd47947;
      4'd6:  r = 17'd45042;
      4'd7:  r = 17'd42313;
      4'd8:  r = 17'd39750;
      4'd9:  r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  // exp(-i/256), Q16
  function automatic logic [16:0] exp_lo(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd65280;
      4'd2:  r = 17'd65026;
      4'd3:  r = 17'd64772;
      4'd4:  r = 17'd64520;
      4'd5:  r = 17'd64268;
      4'd6:  r = 17'd64018;
      4'd7:  r = 17'd63768;
      4'd8:  r = 17'd63520;
      4'd9:  r = 17'd63272;
      4'd10: r = 17'd63025;
      4'd11: r = 17'd62781;
      4'd12: r = 17'd62536;
      4'd13: r = 17'd62291;
      4'd14: r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

  // ln(1 + i/16), Q16
  function automatic logic [15:0] ln_val(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:  r = 16'd0;
      5'd1:  r = 16'd3973;
      5'd2:  r = 16'd7719;
      5'd3:  r = 16'd11262;
      5'd4:  r = 16'd14624;
      5'd5:  r = 16'd17821;
      5'd6:  r = 16'd20870;
      5'd7:  r = 16'd23783;
      5'd8:  r = 16'd26573;
      5'd9:  r = 16'd29248;
      5'd10: r = 16'd31818;
      5'd11: r = 16'd34292;
      5'd12: r = 16'd36675;
      5'd13: r = 16'd38975;
      5'd14: r = 16'd41196;
      5'd15: r = 16'd43345;
      default: r = 16'd45426;
    endcase
    return r;
  endfunction

endpackage

@@ sv/smce_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module smce_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [smce_pkg::NUM_W-1:0]  num,
  input  logic [smce_pkg::SUM_W-1:0]  den,
  output logic [smce_pkg::NUM_W-1:0]  quot,
  output logic                        done
);
  import smce_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] acc_r;
  logic [SUM_W:0]   rem_r;
  logic [SUM_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W:0]   trial;
  logic             ge;

  // One shift-subtract step
  assign trial = {rem_r[SUM_W-1:0], acc_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      acc_r <= {acc_r[NUM_W-2:0], ge};
      rem_r <= ge ? trial - {1'b0, den_r} : trial;
    end
  end

  assign quot = acc_r;
  assign done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

endmodule

@@ sv/smce_dp.sv @@
// Datapath: config registers, row and probability memories, exp/ln units, output register.
module smce_dp #(
  parameter int MAX_VOCAB = smce_pkg::DEF_MAX_VOCAB
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smce_pkg::smce_cmd_t                cmd,
  output smce_pkg::smce_stat_t               stat,
  input  logic                               cfg_we,
  input  logic [smce_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [smce_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic signed [smce_pkg::LOGIT_W-1:0] in_logit_value,
  input  logic [smce_pkg::TGT_W-1:0]         in_target_index,
  input  logic                               in_target_present,
  input  logic                               in_sequence_last,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [smce_pkg::GRAD_W-1:0] out_gradient_value,
  output logic [smce_pkg::GIDX_W-1:0]        out_gradient_index,
  output logic                               out_row_done,
  output logic [smce_pkg::LOSS_W-1:0]        out_mean_loss,
  output logic                               out_loss_valid
);
  import smce_pkg::*;

  localparam int AW = $clog2(MAX_VOCAB);
  localparam int VW = $clog2(MAX_VOCAB + 1);

  function automatic logic [3:0] lead_one(input logic [15:0] p);
    logic [3:0] k;
    k = '0;
    for (int i = 0; i < 16; i++) begin
      if (p[i]) k = 4'(i);
    end
    return k;
  endfunction

  // Configuration registers
  logic [VCFG_W-1:0] vocab_r;
  logic [RCFG_W-1:0] rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vocab_r <= VCFG_W'(64);
      rows_r  <= RCFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOCAB: vocab_r <= cfg_wdata[VCFG_W-1:0];
        CFG_ROWS:  rows_r  <= cfg_wdata[RCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped register values
  logic [VCFG_W-1:0] vc_clamp;
  logic [VW-1:0]     vcnt;
  logic [RCFG_W-1:0] rows;

  always_comb begin
    if (vocab_r < VCFG_W'(2))                  vc_clamp = VCFG_W'(2);
    else if (vocab_r > VCFG_W'(MAX_VOCAB))     vc_clamp = VCFG_W'(MAX_VOCAB);
    else                                       vc_clamp = vocab_r;
    vcnt = VW'(vc_clamp);
    if (rows_r == '0)                          rows = RCFG_W'(1);
    else if (rows_r > RCFG_W'(MAX_ROWS))       rows = RCFG_W'(MAX_ROWS);
    else                                       rows = rows_r;
  end

  // Row collection state
  logic [VW-1:0]              fill_r;
  logic signed [LOGIT_W-1:0]  max_r;
  logic [TGT_W-1:0]           tgt_r;
  logic                       present_r;
  logic                       seq_r;
  logic                       store_ok;

  assign store_ok = fill_r < vcnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      max_r  <= LOGIT_MIN;
    end else if (cmd.row_clr) begin
      fill_r <= '0;
      max_r  <= LOGIT_MIN;
    end else if (cmd.in_take && store_ok) begin
      fill_r <= fill_r + 1'b1;
      if (in_logit_value > max_r) max_r <= in_logit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      tgt_r     <= in_target_index;
      present_r <= in_target_present;
      seq_r     <= in_sequence_last;
    end
  end

  // Entry counter
  logic [AW-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n)          v_r <= '0;
    else if (cmd.v_clr)  v_r <= '0;
    else if (cmd.v_inc)  v_r <= v_r + 1'b1;
  end

  logic v_last, hit, at_tgt;
  assign v_last = VW'(v_r) == vcnt - 1'b1;
  assign hit    = present_r && (tgt_r < TGT_W'(vcnt));
  assign at_tgt = tgt_r == TGT_W'(v_r);

  // Row buffer
  logic signed [LOGIT_W-1:0] lmem [MAX_VOCAB];
  logic signed [LOGIT_W-1:0] lrd_r;

  always_ff @(posedge clk) begin
    if (cmd.in_take && store_ok) lmem[fill_r[AW-1:0]] <= in_logit_value;
    lrd_r <= lmem[v_r];
  end

  // Exp stage 1: difference to max and first table product
  logic signed [LOGIT_W-1:0] xval;
  logic [LOGIT_W:0]          diff, ndiff;
  logic [15:0]               mexp;
  logic [32:0]               prod1;
  logic [33:0]               rnd1;
  logic [PROB_W-1:0]         e1_r;
  logic [3:0]                lo_r;

  always_comb begin
    xval  = (VW'(v_r) < fill_r) ? lrd_r : LOGIT_MIN;
    diff  = {xval[LOGIT_W-1], xval} - {max_r[LOGIT_W-1], max_r};
    ndiff = (LOGIT_W+1)'(0) - diff;
    mexp  = (!diff[LOGIT_W] && diff != '0) ? 16'd0 : ndiff[15:0];
    prod1 = exp_int(mexp[11:8]) * exp_hi(mexp[7:4]);
    rnd1  = 34'(prod1) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    e1_r <= (mexp[15:8] >= 8'd12) ? '0 : rnd1[32:16];
    lo_r <= mexp[3:0];
  end

  // Exp stage 2
  logic [32:0]       prod2;
  logic [33:0]       rnd2;
  logic [PROB_W-1:0] e_r;

  assign prod2 = e1_r * exp_lo(lo_r);
  assign rnd2  = 34'(prod2) + 34'd32768;

  always_ff @(posedge clk) e_r <= rnd2[32:16];

  // Exponent sum
  logic [SUM_W-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (cmd.sum_clr)   sum_r <= '0;
    else if (cmd.e_wr) sum_r <= sum_r + SUM_W'(e_r);
  end

  // Divider and its operand select
  logic [NUM_W-1:0]  div_num;
  logic [SUM_W-1:0]  div_den;
  logic [NUM_W-1:0]  quot;
  logic              div_done;
  logic [PROB_W-1:0] prd_r;
  logic [PROB_W-1:0] gmag;
  logic              gneg;
  logic              g_neg_r;
  logic [LSUM_W-1:0] lsum_r;

  always_comb begin
    gmag = '0;
    gneg = 1'b0;
    if (present_r) begin
      if (hit && at_tgt) begin
        gmag = ONE_Q16 - prd_r;
        gneg = gmag != '0;
      end else begin
        gmag = prd_r;
      end
    end
  end

  always_comb begin
    case (cmd.div_op)
      DIV_PROB: begin
        div_num = NUM_W'({prd_r, 16'h0000}) + NUM_W'(sum_r[SUM_W-1:1]);
        div_den = sum_r;
      end
      DIV_MEAN: begin
        div_num = NUM_W'(lsum_r) + NUM_W'(rows[RCFG_W-1:1]);
        div_den = SUM_W'(rows);
      end
      default: begin
        div_num = NUM_W'(gmag) + NUM_W'(rows[RCFG_W-1:1]);
        div_den = SUM_W'(rows);
      end
    endcase
  end

  smce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_op == DIV_GRAD) g_neg_r <= gneg;
  end

  // Probability memory: holds exponents, then probabilities
  logic [PROB_W-1:0] pmem [MAX_VOCAB];
  logic [PROB_W-1:0] p_val;
  logic [PROB_W-1:0] ptgt_r;

  assign p_val = (sum_r == '0) ? '0 : quot[PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.e_wr || cmd.p_wr) pmem[v_r] <= cmd.e_wr ? e_r : p_val;
    prd_r <= pmem[v_r];
    if (cmd.p_wr && at_tgt) ptgt_r <= p_val;
  end

  // -ln(p) stage 1: normalize
  logic [3:0]  k;
  logic [31:0] shl;
  logic [3:0]  idx_r;
  logic [11:0] fr_r;
  logic [3:0]  k_r;
  logic        pzero_r, pone_r;

  assign k   = lead_one(ptgt_r[15:0]);
  assign shl = {16'h0000, ptgt_r[15:0]} << (5'd16 - {1'b0, k});

  always_ff @(posedge clk) begin
    idx_r   <= shl[15:12];
    fr_r    <= shl[11:0];
    k_r     <= k;
    pzero_r <= ptgt_r == '0;
    pone_r  <= ptgt_r[PROB_W-1];
  end

  // -ln(p) stage 2: interpolate
  logic [15:0]        ln_lo, ln_hi, ln_d;
  logic [27:0]        ln_prod;
  logic [28:0]        ln_rnd;
  logic [4:0]         kk;
  logic [15:0]        lnf_r;
  logic [NEGLN_W-1:0] base_r;

  always_comb begin
    ln_lo   = ln_val({1'b0, idx_r});
    ln_hi   = ln_val({1'b0, idx_r} + 5'd1);
    ln_d    = ln_hi - ln_lo;
    ln_prod = ln_d * fr_r;
    ln_rnd  = 29'(ln_prod) + 29'd2048;
    kk      = 5'd16 - {1'b0, k_r};
  end

  // kk * ln2 reaches 16 * ln2, so the product is formed at full width
  always_ff @(posedge clk) begin
    lnf_r  <= ln_lo + ln_rnd[27:12];
    base_r <= NEGLN_W'(kk) * NEGLN_W'(LN2_Q16);
  end

  // Loss accumulation and mean
  logic [NEGLN_W-1:0] negln;
  logic [LSUM_W:0]    lsum_add;
  logic [LOSS_W-1:0]  mean_r;

  always_comb begin
    if (pzero_r)     negln = EPS_LOSS_Q16;
    else if (pone_r) negln = '0;
    else             negln = base_r - NEGLN_W'(lnf_r);
    lsum_add = (LSUM_W+1)'(lsum_r) + (LSUM_W+1)'(negln);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r <= '0;
    end else if (cmd.ln_upd && hit) begin
      lsum_r <= lsum_add[LSUM_W] ? '1 : lsum_add[LSUM_W-1:0];
    end else if (cmd.mean_take) begin
      lsum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_take) mean_r <= (|quot[NUM_W-1:LOSS_W]) ? '1 : quot[LOSS_W-1:0];
  end

  // Output register
  logic                     out_valid_r;
  logic signed [GRAD_W-1:0] out_grad_r;
  logic [GIDX_W-1:0]        out_idx_r;
  logic                     out_done_r;
  logic [LOSS_W-1:0]        out_mean_r;
  logic                     out_lv_r;
  logic [GRAD_W-1:0]        qext;
  logic                     fin;

  assign qext = {1'b0, quot[PROB_W-1:0]};
  assign fin  = seq_r && v_last;

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.out_load)  out_valid_r <= 1'b1;
    else if (out_ready)     out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_grad_r <= g_neg_r ? GRAD_W'(0) - qext : qext;
      out_idx_r  <= GIDX_W'(v_r);
      out_done_r <= v_last;
      out_mean_r <= fin ? mean_r : '0;
      out_lv_r   <= fin;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_gradient_value = out_grad_r;
  assign out_gradient_index = out_idx_r;
  assign out_row_done       = out_done_r;
  assign out_mean_loss      = out_mean_r;
  assign out_loss_valid     = out_lv_r;

  // Status
  assign stat.v_last   = v_last;
  assign stat.sum_zero = sum_r == '0;
  assign stat.div_done = div_done;
  assign stat.seq_end  = seq_r;
  assign stat.out_free = !out_valid_r || out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= VW'(MAX_VOCAB)) else $error("fill count beyond row buffer");

  a_loss_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lv_r |-> out_done_r) else $error("mean loss not on row end");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.p_wr |-> p_val <= ONE_Q16) else $error("probability above one");

endmodule

@@ sv/smce_ctrl.sv @@
// Controller state machine: sequences collection, exp pass, divide pass, loss and emit.
module smce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_row_last,
  input  logic                  in_sequence_last,
  input  smce_pkg::smce_stat_t  stat,
  output smce_pkg::smce_cmd_t   cmd
);
  import smce_pkg::*;

  state_t state_r, state_nxt;
  logic   take, closing;

  assign take    = in_valid && state_r == S_IDLE;
  assign closing = in_row_last || in_sequence_last;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (take && closing) state_nxt = S_EXP_RD;
      S_EXP_RD:    state_nxt = S_EXP_M1;
      S_EXP_M1:    state_nxt = S_EXP_M2;
      S_EXP_M2:    state_nxt = S_EXP_WR;
      S_EXP_WR:    state_nxt = stat.v_last ? S_DIV_RD : S_EXP_RD;
      S_DIV_RD:    state_nxt = S_DIV_GO;
      S_DIV_GO:    state_nxt = stat.sum_zero ? S_DIV_WR : S_DIV_WAIT;
      S_DIV_WAIT:  if (stat.div_done) state_nxt = S_DIV_WR;
      S_DIV_WR:    state_nxt = stat.v_last ? S_LN1 : S_DIV_RD;
      S_LN1:       state_nxt = S_LN2;
      S_LN2:       state_nxt = S_LN3;
      S_LN3:       state_nxt = stat.seq_end ? S_MEAN_GO : S_EM_RD;
      S_MEAN_GO:   state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (stat.div_done) state_nxt = S_EM_RD;
      S_EM_RD:     state_nxt = S_EM_GO;
      S_EM_GO:     state_nxt = S_EM_WAIT;
      S_EM_WAIT:   if (stat.div_done) state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (stat.out_free) state_nxt = stat.v_last ? S_IDLE : S_EM_RD;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_take = take;
        if (take && closing) begin
          cmd.v_clr   = 1'b1;
          cmd.sum_clr = 1'b1;
        end
      end
      S_EXP_WR: begin
        cmd.e_wr  = 1'b1;
        cmd.v_clr = stat.v_last;
        cmd.v_inc = !stat.v_last;
      end
      S_DIV_GO: begin
        cmd.div_op    = DIV_PROB;
        cmd.div_start = !stat.sum_zero;
      end
      S_DIV_WR: begin
        cmd.p_wr  = 1'b1;
        cmd.v_clr = stat.v_last;
        cmd.v_inc = !stat.v_last;
      end
      S_LN3:       cmd.ln_upd = 1'b1;
      S_MEAN_GO: begin
        cmd.div_op    = DIV_MEAN;
        cmd.div_start = 1'b1;
      end
      S_MEAN_WAIT: begin
        cmd.div_op    = DIV_MEAN;
        cmd.mean_take = stat.div_done;
      end
      S_EM_GO: begin
        cmd.div_op    = DIV_GRAD;
        cmd.div_start = 1'b1;
      end
      S_EM_WAIT:   cmd.div_op = DIV_GRAD;
      S_EM_OUT: begin
        cmd.div_op = DIV_GRAD;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.row_clr  = stat.v_last;
          cmd.v_inc    = !stat.v_last;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/softmax_cross_entropy_loss_grad_top.sv @@
// Top level of the softmax cross-entropy loss and gradient block.
//
// Input channel (in_valid/in_ready): one Q8.8 logit per request, in vocabulary
// order; the request with in_row_last (or in_sequence_last) closes the row and
// carries its target. Non-closing requests take one cycle each.
// Output channel (out_valid/out_ready): vocab_count gradient requests per
// closed row, Q1.16, with out_row_done on the last; after the sequence's last
// row that final request also carries out_mean_loss with out_loss_valid.
// Configuration: cfg_we with cfg_index 0 (vocab_count) or 1 (sequence_rows), to be
// written by the user only while the block is idle; the block does not enforce it.
// Processing: after a closing request the block runs an exp pass over the row, a
// divide pass through the shared bit-serial divider, the loss update, the mean
// division at sequence end, and an emit pass that uses the divider once per
// entry. No new logit is taken until the row's last gradient is loaded.
// Reset clears the row fill, running max, loss sum and output valid; registers
// return to 64 entries and 1 row. A stalled receiver holds the output register
// and the emit pass waits on it without losing a request.
module softmax_cross_entropy_loss_grad_top #(
  parameter int MAX_VOCAB = smce_pkg::DEF_MAX_VOCAB
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [smce_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [smce_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [smce_pkg::LOGIT_W-1:0] in_logit_value,
  input  logic [smce_pkg::TGT_W-1:0]         in_target_index,
  input  logic                               in_target_present,
  input  logic                               in_row_last,
  input  logic                               in_sequence_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [smce_pkg::GRAD_W-1:0] out_gradient_value,
  output logic [smce_pkg::GIDX_W-1:0]        out_gradient_index,
  output logic                               out_row_done,
  output logic [smce_pkg::LOSS_W-1:0]        out_mean_loss,
  output logic                               out_loss_valid
);
  import smce_pkg::*;

  smce_cmd_t  cmd;
  smce_stat_t stat;

  smce_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_row_last      (in_row_last),
    .in_sequence_last (in_sequence_last),
    .stat             (stat),
    .cmd              (cmd)
  );

  smce_dp #(.MAX_VOCAB(MAX_VOCAB)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_logit_value     (in_logit_value),
    .in_target_index    (in_target_index),
    .in_target_present  (in_target_present),
    .in_sequence_last   (in_sequence_last),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_gradient_value (out_gradient_value),
    .out_gradient_index (out_gradient_index),
    .out_row_done       (out_row_done),
    .out_mean_loss      (out_mean_loss),
    .out_loss_valid     (out_loss_valid)
  );

endmodule

@@ tb/softmax_cross_entropy_loss_grad_top_test.sv @@
// Self-checking testbench for the softmax cross-entropy loss and gradient block.
module softmax_cross_entropy_loss_grad_top_test;
  import smce_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic [TGT_W-1:0]          tgt;
    logic                      present;
    logic                      row_last;
    logic                      seq_last;
  } logit_req_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad;
    logic [GIDX_W-1:0]        idx;
    logic                     done;
    logic [LOSS_W-1:0]        mean;
    logic                     loss_valid;
  } grad_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_VOCAB;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [LOGIT_W-1:0] in_logit_value = '0;
  logic [TGT_W-1:0] in_target_index = '0;
  logic in_target_present = 1'b0;
  logic in_row_last = 1'b0;
  logic in_sequence_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [GRAD_W-1:0] out_gradient_value;
  logic [GIDX_W-1:0] out_gradient_index;
  logic out_row_done;
  logic [LOSS_W-1:0] out_mean_loss;
  logic out_loss_valid;

  softmax_cross_entropy_loss_grad_top uut (.*);

  always #5 clk = ~clk;

  // Own copies of the fixed-point tables
  localparam int unsigned EXP_I [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                        22, 8, 3, 1};
  localparam int unsigned EXP_H [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                        42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                        27319, 25664};
  localparam int unsigned EXP_L [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                        63768, 63520, 63272, 63025, 62781, 62536, 62291,
                                        62048, 61806};
  localparam int unsigned LN_T [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
                                       26573, 29248, 31818, 34292, 36675, 38975, 41196,
                                       43345, 45426};

  // Predictor state
  logic [VCFG_W-1:0] vocab_reg = 7'd64;
  logic [RCFG_W-1:0] rows_reg  = 11'd1;
  int row_buf [DEF_MAX_VOCAB];
  int unsigned fill_cnt = 0;
  int row_max = -32768;
  longint unsigned loss_acc = 0;

  logit_req_t pending_reqs[$];
  grad_res_t  expected_grads[$];
  int errors = 0;
  int reqs_taken = 0;
  int grads_seen = 0;
  int idle_cycles = 0;
  int phases = 0;

  function automatic int unsigned vocab_eff();
    return (vocab_reg < 2) ? 2 : (vocab_reg > DEF_MAX_VOCAB) ? DEF_MAX_VOCAB : vocab_reg;
  endfunction

  function automatic int unsigned rows_eff();
    return (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
  endfunction

  function automatic longint unsigned exp_fx(int unsigned m);
    longint unsigned e;
    if ((m >> 8) >= 12) return 0;
    e = (longint'(EXP_I[m >> 8]) * EXP_H[(m >> 4) & 15] + 32768) >> 16;
    e = (e * EXP_L[m & 15] + 32768) >> 16;
    return e;
  endfunction

  function automatic longint unsigned neg_ln_fx(longint unsigned p);
    int unsigned k;
    int unsigned m;
    int unsigned ix;
    int unsigned fr;
    int unsigned lnf;
    if (p == 0) return 1509022;
    if (p >= 65536) return 0;
    k = 15;
    while ((p >> k) == 0) k--;
    m = 32'((p << (16 - k)) & 16'hFFFF);
    ix = m >> 12;
    fr = m & 12'hFFF;
    lnf = LN_T[ix] + (((LN_T[ix+1] - LN_T[ix]) * fr + 2048) >> 12);
    return (16 - k) * 45426 - lnf;
  endfunction

  // Update the model with one accepted logit; queue the row's gradients on a close
  task automatic predict_logit(logit_req_t r);
    int unsigned vc;
    int unsigned rc;
    int unsigned n;
    longint unsigned probs [DEF_MAX_VOCAB];
    longint unsigned sum;
    longint unsigned mag;
    longint unsigned q;
    longint g;
    int d;
    bit hit;
    grad_res_t res;
    vc = vocab_eff();
    rc = rows_eff();
    sum = 0;
    if (fill_cnt < vc) begin
      row_buf[fill_cnt] = r.logit;
      fill_cnt++;
      if (r.logit > row_max) row_max = r.logit;
    end
    if (!(r.row_last || r.seq_last)) return;
    n = (fill_cnt < vc) ? fill_cnt : vc;
    for (int v = 0; v < vc; v++) begin
      d = ((v < n) ? row_buf[v] : -32768) - row_max;
      if (d > 0) d = 0;
      probs[v] = exp_fx(-d);
      sum += probs[v];
    end
    for (int v = 0; v < vc; v++)
      probs[v] = (sum == 0) ? 0 : (probs[v] * 65536 + sum / 2) / sum;
    hit = r.present && (r.tgt < vc);
    if (hit) begin
      loss_acc += neg_ln_fx(probs[r.tgt]);
      if (loss_acc > 64'hFFFF_FFFF) loss_acc = 64'hFFFF_FFFF;
    end
    for (int v = 0; v < vc; v++) begin
      g = 0;
      if (r.present) begin
        g = probs[v];
        if (hit && v == r.tgt) g -= 65536;
      end
      mag = (g < 0) ? -g : g;
      q = (mag + rc / 2) / rc;
      res.grad = GRAD_W'((g < 0) ? -longint'(q) : longint'(q));
      res.idx = GIDX_W'(v);
      res.done = (v == vc - 1);
      res.mean = '0;
      res.loss_valid = 1'b0;
      if (r.seq_last && v == vc - 1) begin
        q = (loss_acc + rc / 2) / rc;
        res.mean = (q > 24'hFFFFFF) ? 24'hFFFFFF : LOSS_W'(q);
        res.loss_valid = 1'b1;
      end
      expected_grads = {expected_grads, res};
    end
    if (r.seq_last) loss_acc = 0;
    fill_cnt = 0;
    row_max = -32768;
  endtask

  // Sender: idles per stage, holds the request until it is taken
  always @(posedge clk) begin
    int send_idle;
    send_idle = (reqs_taken < 150) ? 38 : (reqs_taken < 300) ? 67 : 0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_logit({in_logit_value, in_target_index, in_target_present,
                       in_row_last, in_sequence_last});
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          logit_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_logit_value <= r.logit;
          in_target_index <= r.tgt;
          in_target_present <= r.present;
          in_row_last <= r.row_last;
          in_sequence_last <= r.seq_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, compare each gradient with the oldest expectation
  always @(posedge clk) begin
    int recv_idle;
    grad_res_t e;
    recv_idle = (reqs_taken < 150) ? 67 : (reqs_taken < 300) ? 38 : 0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        grads_seen++;
        if (expected_grads.size() == 0) begin
          $error("unexpected gradient request idx=%0d", out_gradient_index);
          errors++;
        end else begin
          e = expected_grads.pop_front();
          if (out_gradient_value !== e.grad) begin
            $error("gradient_value exp %0d got %0d", e.grad, out_gradient_value);
            errors++;
          end
          if (out_gradient_index !== e.idx) begin
            $error("gradient_index exp %0d got %0d", e.idx, out_gradient_index);
            errors++;
          end
          if (out_row_done !== e.done) begin
            $error("row_done exp %0d got %0d", e.done, out_row_done);
            errors++;
          end
          if (out_mean_loss !== e.mean) begin
            $error("mean_loss exp %0d got %0d", e.mean, out_mean_loss);
            errors++;
          end
          if (out_loss_valid !== e.loss_valid) begin
            $error("loss_valid exp %0d got %0d", e.loss_valid, out_loss_valid);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("softmax_cross_entropy_loss_grad_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(val);
    if (idx == CFG_VOCAB) vocab_reg = val[VCFG_W-1:0];
    else rows_reg = val[RCFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued request is sent and every expected gradient has arrived
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_grads.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_logit(int x, int tgt, bit pres, bit rl, bit sl);
    logit_req_t r;
    r.logit = LOGIT_W'(x);
    r.tgt = TGT_W'(tgt);
    r.present = pres;
    r.row_last = rl;
    r.seq_last = sl;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic int rand_logit();
    return ($urandom_range(1) == 0) ? int'($urandom_range(65535)) - 32768
                                    : int'($urandom_range(2047)) - 1024;
  endfunction

  // Random rows, mostly well formed, with short, long and odd-target rows mixed in
  task automatic random_phase(int unsigned v_raw, int unsigned r_raw, int n_items);
    int unsigned vc;
    int len;
    int tgt;
    int shape;
    int rows_left;
    bit pres;
    bit sl;
    bit rl;
    write_reg(CFG_VOCAB, v_raw);
    write_reg(CFG_ROWS, r_raw);
    vc = vocab_eff();
    phases++;
    rows_left = $urandom_range(1, 6);
    while (n_items > 0) begin
      shape = $urandom_range(99);
      len = (shape < 80) ? vc : (shape < 90) ? $urandom_range(1, vc - 1)
                                             : vc + $urandom_range(1, 3);
      shape = $urandom_range(99);
      pres = (shape >= 10);
      tgt = (shape < 80) ? $urandom_range(vc - 1) : $urandom_range(vc, 255);
      rows_left--;
      sl = (rows_left == 0) || (n_items <= len);
      if (sl) rows_left = $urandom_range(1, 6);
      rl = !sl || ($urandom_range(3) != 0);
      for (int i = 0; i < len - 1; i++)
        push_logit(rand_logit(), $urandom_range(255), $urandom_range(1) != 0, 1'b0, 1'b0);
      push_logit(rand_logit(), tgt, pres, rl, sl);
      n_items -= len;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings, short row at full vocabulary, extreme logits
    push_logit(32767, 5, 1'b1, 1'b0, 1'b0);
    push_logit(-32768, 0, 1'b0, 1'b0, 1'b0);
    push_logit(0, 2, 1'b1, 1'b0, 1'b1);
    drain();

    // No target, out-of-vocabulary target, extra logits, close by sequence end only
    write_reg(CFG_VOCAB, 4);
    write_reg(CFG_ROWS, 3);
    for (int i = 0; i < 3; i++) push_logit(i * 100, 0, 1'b0, 1'b0, 1'b0);
    push_logit(-50, 1, 1'b0, 1'b1, 1'b0);
    push_logit(256, 0, 1'b1, 1'b1, 1'b0);
    for (int i = 0; i < 5; i++) push_logit(-i * 300, 0, 1'b0, 1'b0, 1'b0);
    push_logit(700, 200, 1'b1, 1'b1, 1'b0);
    push_logit(10, 0, 1'b1, 1'b0, 1'b1);
    drain();

    // Vocabulary shrunk in the middle of a row
    write_reg(CFG_VOCAB, 8);
    for (int i = 0; i < 5; i++) push_logit(1000 - i * 600, 0, 1'b0, 1'b0, 1'b0);
    drain();
    write_reg(CFG_VOCAB, 3);
    push_logit(2000, 1, 1'b1, 1'b1, 1'b1);
    drain();

    // Zero-probability targets until the mean loss saturates; rows register clamps to 1
    write_reg(CFG_VOCAB, 2);
    write_reg(CFG_ROWS, 0);
    for (int i = 0; i < 12; i++) begin
      push_logit(32767, 0, 1'b0, 1'b0, 1'b0);
      push_logit(-32768, 1, 1'b1, 1'b1, i == 11);
    end
    drain();

    random_phase(2, 1024, 45);
    random_phase(5, 7, 55);
    random_phase(0, 2047, 35);
    random_phase(8, 1, 55);
    random_phase(127, 2, 55);
    random_phase(3, 100, 40);
    random_phase(64, 0, 64);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_grads.size() != 0) begin
      $error("%0d gradient requests never arrived", expected_grads.size());
      errors++;
    end
    $display("Checked %0d logit requests and %0d gradient requests across %0d settings,",
             reqs_taken, grads_seen, phases + 4);
    $display("including short, long, targetless and saturating rows under random stalls.");
    if (errors == 0) begin
      $display("softmax_cross_entropy_loss_grad_top verification clean");
    end else begin
      $display("softmax_cross_entropy_loss_grad_top verification failed");
    end
    $finish;
  end

endmodule

@@ softmax_cross_entropy_loss_grad_top.f @@
sv/smce_pkg.sv
sv/smce_div.sv
sv/smce_dp.sv
sv/smce_ctrl.sv
sv/softmax_cross_entropy_loss_grad_top.sv
tb/softmax_cross_entropy_loss_grad_top_test.sv
